// File: rtl/core/uvlds_pkg.sv
package uvlds_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_MINUTE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STANDBY_HOURS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RUN_MINUTES      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_TICKS      = 3'd3;

   localparam logic [9:0] TICKS_PER_MINUTE_RST = 10'd600;
   localparam logic [7:0] STANDBY_HOURS_RST    = 8'd6;
   localparam logic [7:0] RUN_MINUTES_RST      = 8'd120;
   localparam logic [7:0] RETRY_TICKS_RST      = 8'd30;

   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

   localparam int OFF_LID   = 0;
   localparam int OFF_RETRY = 1;
   localparam int OFF_ERROR = 2;

   typedef enum logic {
      PH_STANDBY = 1'b0,
      PH_RUN     = 1'b1
   } phase_type;

   typedef struct packed {
      logic self_test_active;
      logic install_flushing;
      logic fault_test_active;
      logic fault_test_lamp_on;
      logic lid_closed;
      logic retry_request;
      logic lamp_error;
   } req_type;

   typedef struct packed {
      logic       uv_drive;
      logic       schedule_on;
      logic       run_phase;
      logic [2:0] off_reasons;
   } rsp_type;

   typedef struct packed {
      logic [9:0] ticks_per_minute;
      logic [7:0] standby_hours;
      logic [7:0] run_minutes;
      logic [7:0] retry_ticks;
   } cfg_type;

   typedef struct packed {
      logic run_phase;
      logic req_on;
   } sched_out_type;

endpackage

// File: rtl/core/uvlds_csr.sv
module uvlds_csr
   import uvlds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TICKS_PER_MINUTE: cfg_in.ticks_per_minute = csr_wdata[9:0];
            CSR_STANDBY_HOURS:    cfg_in.standby_hours    = csr_wdata[7:0];
            CSR_RUN_MINUTES:      cfg_in.run_minutes      = csr_wdata[7:0];
            CSR_RETRY_TICKS:      cfg_in.retry_ticks      = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_minute <= TICKS_PER_MINUTE_RST;
         cfg_ff.standby_hours    <= STANDBY_HOURS_RST;
         cfg_ff.run_minutes      <= RUN_MINUTES_RST;
         cfg_ff.retry_ticks      <= RETRY_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/uvlds_sched.sv
module uvlds_sched
   import uvlds_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic          flushing,
   input  logic [2:0]    off_bits,
   input  cfg_type       cfg,
   output sched_out_type sched_out
);

   phase_type  phase_ff,    phase_in;
   logic       run_en_ff,   run_en_in;
   logic [9:0] std_tick_ff, std_tick_in;
   logic [5:0] std_min_ff,  std_min_in;
   logic [7:0] std_hour_ff, std_hour_in;
   logic [9:0] run_tick_ff, run_tick_in;
   logic [7:0] run_min_ff,  run_min_in;

   logic [9:0] std_tick_inc;
   logic       std_tick_wrap;
   logic [9:0] std_tick_nx;
   logic [5:0] std_min_inc;
   logic       std_min_wrap;
   logic [5:0] std_min_nx;
   logic [7:0] std_hour_nx;
   logic       standby_done;
   logic [9:0] run_tick_inc;
   logic       run_tick_wrap;
   logic [9:0] run_tick_nx;
   logic [7:0] run_min_nx;
   logic       run_done;

   // standby and run timers
   always_comb begin
      std_tick_inc  = std_tick_ff + 10'd1;
      std_tick_wrap = std_tick_inc >= cfg.ticks_per_minute;
      std_tick_nx   = std_tick_wrap ? 10'd0 : std_tick_inc;
      std_min_inc   = std_tick_wrap ? std_min_ff + 6'd1 : std_min_ff;
      std_min_wrap  = std_min_inc >= MINUTES_PER_HOUR;
      std_min_nx    = std_min_wrap ? 6'd0 : std_min_inc;
      std_hour_nx   = std_min_wrap ? std_hour_ff + 8'd1 : std_hour_ff;
      standby_done  = std_hour_nx >= cfg.standby_hours;

      run_tick_inc  = run_tick_ff + 10'd1;
      run_tick_wrap = run_tick_inc >= cfg.ticks_per_minute;
      run_tick_nx   = run_tick_wrap ? 10'd0 : run_tick_inc;
      run_min_nx    = run_tick_wrap ? run_min_ff + 8'd1 : run_min_ff;
      run_done      = run_min_nx >= cfg.run_minutes;
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      run_en_in   = run_en_ff;
      std_tick_in = std_tick_ff;
      std_min_in  = std_min_ff;
      std_hour_in = std_hour_ff;
      run_tick_in = run_tick_ff;
      run_min_in  = run_min_ff;
      if (step) begin
         if (flushing) begin
            phase_in    = PH_STANDBY;
            run_en_in   = 1'b0;
            std_tick_in = '0;
            std_min_in  = '0;
            std_hour_in = '0;
            run_tick_in = '0;
            run_min_in  = '0;
         end else if (phase_ff == PH_STANDBY) begin
            if (standby_done) begin
               phase_in    = PH_RUN;
               run_en_in   = 1'b1;
               std_tick_in = '0;
               std_min_in  = '0;
               std_hour_in = '0;
               run_tick_in = '0;
               run_min_in  = '0;
            end else begin
               std_tick_in = std_tick_nx;
               std_min_in  = std_min_nx;
               std_hour_in = std_hour_nx;
            end
         end else if (run_en_ff) begin
            if (off_bits == 3'b000) begin
               if (run_done) begin
                  run_en_in   = 1'b0;
                  std_tick_in = '0;
                  std_min_in  = '0;
                  std_hour_in = '0;
                  run_tick_in = '0;
                  run_min_in  = '0;
               end else begin
                  run_tick_in = run_tick_nx;
                  run_min_in  = run_min_nx;
               end
            end
         end else begin
            phase_in = PH_STANDBY;
         end
      end
   end

   // outputs
   always_comb begin
      sched_out.run_phase = (phase_in == PH_RUN);
      sched_out.req_on    = step && !flushing && (phase_ff == PH_RUN) && run_en_ff &&
                            (off_bits == 3'b000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_STANDBY;
         run_en_ff   <= 1'b0;
         std_tick_ff <= '0;
         std_min_ff  <= '0;
         std_hour_ff <= '0;
         run_tick_ff <= '0;
         run_min_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         run_en_ff   <= run_en_in;
         std_tick_ff <= std_tick_in;
         std_min_ff  <= std_min_in;
         std_hour_ff <= std_hour_in;
         run_tick_ff <= run_tick_in;
         run_min_ff  <= run_min_in;
      end
   end

   a_run_en_in_run_phase: assert property (@(posedge clock) disable iff (reset)
      run_en_ff |-> (phase_ff == PH_RUN))
      else $error("run enabled outside run phase");

   a_standby_min_range: assert property (@(posedge clock) disable iff (reset)
      std_min_ff < MINUTES_PER_HOUR)
      else $error("standby minute count out of range");

   a_standby_clear_in_run: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RUN) |-> (std_tick_ff == '0 && std_min_ff == '0 && std_hour_ff == '0))
      else $error("standby timers not cleared in run phase");

endmodule

// File: rtl/core/uvlds_lamp.sv
module uvlds_lamp
   import uvlds_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  req_type    req_data,
   input  logic       req_on,
   input  logic       run_phase,
   input  cfg_type    cfg,
   output logic [2:0] off_bits,
   output rsp_type    res
);

   logic       hold_ff,  hold_in;
   logic [7:0] cnt_ff,   cnt_in;
   logic [2:0] offs_ff,  offs_in;
   logic       drive_ff, drive_in;
   logic       sched_ff, sched_in;

   logic       hold_set;
   logic [7:0] cnt_inc;
   logic       release_hold;
   logic [2:0] offs_now;
   logic       ft_bit;

   always_comb begin
      hold_set     = hold_ff | req_data.retry_request;
      cnt_inc      = cnt_ff + 8'd1;
      release_hold = cnt_inc >= cfg.retry_ticks;
      ft_bit       = req_data.fault_test_active & req_data.fault_test_lamp_on;

      offs_now            = '0;
      offs_now[OFF_LID]   = !req_data.lid_closed;
      offs_now[OFF_RETRY] = hold_set && !release_hold;
      offs_now[OFF_ERROR] = req_data.lamp_error;

      hold_in  = hold_ff;
      cnt_in   = cnt_ff;
      offs_in  = offs_ff;
      drive_in = drive_ff;
      sched_in = sched_ff;
      if (step) begin
         if (hold_set) begin
            hold_in = !release_hold;
            cnt_in  = release_hold ? 8'd0 : cnt_inc;
         end else begin
            cnt_in = 8'd0;
         end
         offs_in  = offs_now;
         drive_in = (offs_now == 3'b000) && (req_on || ft_bit);
         sched_in = req_on;
      end
   end

   assign off_bits        = offs_ff;
   assign res.uv_drive    = drive_in;
   assign res.schedule_on = sched_in;
   assign res.run_phase   = run_phase;
   assign res.off_reasons = offs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         cnt_ff   <= '0;
         offs_ff  <= '0;
         drive_ff <= 1'b0;
         sched_ff <= 1'b0;
      end else begin
         hold_ff  <= hold_in;
         cnt_ff   <= cnt_in;
         offs_ff  <= offs_in;
         drive_ff <= drive_in;
         sched_ff <= sched_in;
      end
   end

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !hold_ff |-> (cnt_ff == '0))
      else $error("retry count running without hold");

   a_drive_needs_clear: assert property (@(posedge clock) disable iff (reset)
      drive_ff |-> (offs_ff == 3'b000))
      else $error("lamp driven with an off reason set");

   a_hold_reported: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> offs_ff[OFF_RETRY])
      else $error("retry hold latched but not reported");

endmodule

// File: rtl/core/uv_lamp_duty_scheduler_top.sv
// the response to an accepted request is registered and shown in the cycle after its acceptance
// throughput: one request per cycle while req_stall is low, the response register frees as it is taken
// req_stall rises only while a finished response waits under rsp_stall
// reset clears the schedule, timers, retry hold, drive and response valid
// and returns the control registers to their default values
module uv_lamp_duty_scheduler_top
   import uvlds_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;
   sched_out_type sched_out;
   logic [2:0]    off_bits;
   rsp_type       res;
   logic          accept;
   logic          step;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign step      = accept && !req_data.self_test_active;

   uvlds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uvlds_sched u_sched (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .flushing  (req_data.install_flushing),
      .off_bits  (off_bits),
      .cfg       (cfg),
      .sched_out (sched_out)
   );

   uvlds_lamp u_lamp (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req_data  (req_data),
      .req_on    (sched_out.req_on),
      .run_phase (sched_out.run_phase),
      .cfg       (cfg),
      .off_bits  (off_bits),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = accept ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_self_test_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.self_test_active && rsp_valid_ff) |=>
      (rsp_data_ff.run_phase == $past(sched_out.run_phase)))
      else $error("self test changed the phase");

   a_drive_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.uv_drive) |-> (rsp_data_ff.off_reasons == 3'b000))
      else $error("response drives lamp with an off reason");

endmodule
